// ===== rtl/fet_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_pkg
// Shared types, codes and arithmetic helpers of the flector element transform.
// ----------------------------------------------------------------------------
package fet_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DW            = 32;
  localparam int SUM_W         = 72;
  localparam int NREG          = 8;
  localparam int AW            = 5;
  localparam int RIDX_W        = 3;

  typedef logic signed [DW-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_VECTOR    = 3'd0,
    ACT_BIVECTOR  = 3'd1,
    ACT_POINT     = 3'd2,
    ACT_LINE      = 3'd3,
    ACT_PLANE     = 3'd4
  } action_t;

  typedef enum logic [RIDX_W-1:0] {
    REG_SX = 3'd0,
    REG_SY = 3'd1,
    REG_SZ = 3'd2,
    REG_SW = 3'd3,
    REG_HX = 3'd4,
    REG_HY = 3'd5,
    REG_HZ = 3'd6,
    REG_HW = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][2:0][DW-1:0] rot;
    logic [2:0][2:0][DW-1:0] dirm;
    logic [2:0][2:0][DW-1:0] cpl;
    logic [2:0][DW-1:0]      trn;
    logic [2:0][DW-1:0]      pln;
    logic                    ovf_rot;
    logic                    ovf_trn;
    logic                    ovf_dir;
    logic                    ovf_pln;
  } coef_t;

  typedef struct packed {
    logic en1;
    logic en2;
  } coef_ctl_t;

  // Exact product, rounded half up to frac fraction bits.
  function automatic logic signed [63:0] qmul(input logic signed [DW-1:0] a,
                                              input logic signed [DW-1:0] b,
                                              input int frac);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return (p + (64'sd1 <<< (frac - 1))) >>> frac;
  endfunction

  function automatic logic sat_hit(input logic signed [SUM_W-1:0] x);
    return x[SUM_W-1:DW-1] != {(SUM_W-DW+1){x[DW-1]}};
  endfunction

  function automatic word_t sat_word(input logic signed [SUM_W-1:0] x);
    word_t r;
    if (sat_hit(x)) begin
      r = x[SUM_W-1] ? word_t'(32'h8000_0000) : word_t'(32'h7FFF_FFFF);
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/fet_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_ifs
// Element and result channels of the flector element transform.
// ----------------------------------------------------------------------------
interface fet_elem_if;
  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic signed [31:0]  in_a;
  logic signed [31:0]  in_b;
  logic signed [31:0]  in_c;
  logic signed [31:0]  in_d;
  logic signed [31:0]  in_e;
  logic signed [31:0]  in_f;

  modport source (output valid, action, in_a, in_b, in_c, in_d, in_e, in_f,
                  input ready);
  modport sink (input valid, action, in_a, in_b, in_c, in_d, in_e, in_f,
                output ready);
endinterface

interface fet_result_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  out_a;
  logic signed [31:0]  out_b;
  logic signed [31:0]  out_c;
  logic signed [31:0]  out_d;
  logic signed [31:0]  out_e;
  logic signed [31:0]  out_f;
  logic                overflow;

  modport source (output valid, out_a, out_b, out_c, out_d, out_e, out_f, overflow,
                  input ready);
  modport sink (input valid, out_a, out_b, out_c, out_d, out_e, out_f, overflow,
                output ready);
endinterface

// ===== rtl/fet_coef.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_coef
// Two-stage coefficient unit: register products, then saturated sums.
// ----------------------------------------------------------------------------
module fet_coef #(
  parameter int FRAC_BITS = fet_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic [fet_pkg::NREG-1:0][fet_pkg::DW-1:0]  cfg,
  input  fet_pkg::coef_ctl_t                         ctl,
  output fet_pkg::coef_t                             coef
);

  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = fet_pkg::SUM_W;

  fet_pkg::word_t sx, sy, sz, sw, hx, hy, hz, hw;

  logic signed [PW-1:0] sw2, hx2, hy2, hz2, hyhz, hzhx, hxhy, hxsw, hysw, hzsw;
  logic signed [PW-1:0] sxsw, sysw, szsw, hxhw, hyhw, hzhw, hysz, hzsy, hzsx;
  logic signed [PW-1:0] hxsz, hxsy, hysx, hysy, hzsz, hxsx;

  logic signed [SW-1:0] rs [3][3];
  logic signed [SW-1:0] ds [3][3];
  logic signed [SW-1:0] cs [3][3];
  logic signed [SW-1:0] ts [3];
  logic signed [SW-1:0] ps [3];

  function automatic logic signed [PW-1:0] qm(input fet_pkg::word_t a,
                                              input fet_pkg::word_t b);
    return PW'(fet_pkg::qmul(a, b, FRAC_BITS));
  endfunction

  function automatic logic signed [SW-1:0] ex(input logic signed [PW-1:0] v);
    return SW'(v);
  endfunction

  assign sx = cfg[fet_pkg::REG_SX];
  assign sy = cfg[fet_pkg::REG_SY];
  assign sz = cfg[fet_pkg::REG_SZ];
  assign sw = cfg[fet_pkg::REG_SW];
  assign hx = cfg[fet_pkg::REG_HX];
  assign hy = cfg[fet_pkg::REG_HY];
  assign hz = cfg[fet_pkg::REG_HZ];
  assign hw = cfg[fet_pkg::REG_HW];

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      sw2  <= qm(sw, sw);
      hx2  <= qm(hx, hx);
      hy2  <= qm(hy, hy);
      hz2  <= qm(hz, hz);
      hyhz <= qm(hy, hz);
      hzhx <= qm(hz, hx);
      hxhy <= qm(hx, hy);
      hxsw <= qm(hx, sw);
      hysw <= qm(hy, sw);
      hzsw <= qm(hz, sw);
      sxsw <= qm(sx, sw);
      sysw <= qm(sy, sw);
      szsw <= qm(sz, sw);
      hxhw <= qm(hx, hw);
      hyhw <= qm(hy, hw);
      hzhw <= qm(hz, hw);
      hysz <= qm(hy, sz);
      hzsy <= qm(hz, sy);
      hzsx <= qm(hz, sx);
      hxsz <= qm(hx, sz);
      hxsy <= qm(hx, sy);
      hysx <= qm(hy, sx);
      hysy <= qm(hy, sy);
      hzsz <= qm(hz, sz);
      hxsx <= qm(hx, sx);
    end
  end

  always_comb begin
    rs[0][0] = -(ex(hx2) + ex(sw2));
    rs[0][1] = ex(hzsw) - ex(hxhy);
    rs[0][2] = -(ex(hzhx) + ex(hysw));
    rs[1][0] = -(ex(hxhy) + ex(hzsw));
    rs[1][1] = -(ex(hy2) + ex(sw2));
    rs[1][2] = ex(hxsw) - ex(hyhz);
    rs[2][0] = ex(hysw) - ex(hzhx);
    rs[2][1] = -(ex(hyhz) + ex(hxsw));
    rs[2][2] = -(ex(hz2) + ex(sw2));

    ds[0][0] = -(ex(hy2) + ex(hz2));
    ds[0][1] = ex(hxhy) - ex(hzsw);
    ds[0][2] = ex(hzhx) + ex(hysw);
    ds[1][0] = ex(hxhy) + ex(hzsw);
    ds[1][1] = -(ex(hz2) + ex(hx2));
    ds[1][2] = ex(hyhz) - ex(hxsw);
    ds[2][0] = ex(hzhx) - ex(hysw);
    ds[2][1] = ex(hyhz) + ex(hxsw);
    ds[2][2] = -(ex(hx2) + ex(hy2));

    cs[0][0] = -((ex(hysy) + ex(hzsz)) <<< 1);
    cs[0][1] = ex(hxsy) + ex(hysx) - ex(szsw) - ex(hzhw);
    cs[0][2] = ex(hxsz) + ex(hzsx) + ex(sysw) + ex(hyhw);
    cs[1][0] = ex(hysx) + ex(hxsy) + ex(szsw) + ex(hzhw);
    cs[1][1] = -((ex(hzsz) + ex(hxsx)) <<< 1);
    cs[1][2] = ex(hysz) + ex(hzsy) - ex(sxsw) - ex(hxhw);
    cs[2][0] = ex(hzsx) + ex(hxsz) - ex(sysw) - ex(hyhw);
    cs[2][1] = ex(hzsy) + ex(hysz) + ex(sxsw) + ex(hxhw);
    cs[2][2] = -((ex(hxsx) + ex(hysy)) <<< 1);

    ts[0] = ex(sxsw) - ex(hxhw) + ex(hysz) - ex(hzsy);
    ts[1] = ex(sysw) - ex(hyhw) + ex(hzsx) - ex(hxsz);
    ts[2] = ex(szsw) - ex(hzhw) + ex(hxsy) - ex(hysx);

    ps[0] = ex(sxsw) - ex(hxhw) - ex(hysz) + ex(hzsy);
    ps[1] = ex(sysw) - ex(hyhw) - ex(hzsx) + ex(hxsz);
    ps[2] = ex(szsw) - ex(hzhw) - ex(hxsy) + ex(hysx);
  end

  always_ff @(posedge clk) begin
    logic o_rot, o_dir, o_trn, o_pln;
    if (ctl.en2) begin
      o_rot = 1'b0;
      o_dir = 1'b0;
      o_trn = 1'b0;
      o_pln = 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          coef.rot[i][j]  <= fet_pkg::sat_word(rs[i][j]);
          coef.dirm[i][j] <= fet_pkg::sat_word(ds[i][j]);
          coef.cpl[i][j]  <= fet_pkg::sat_word(cs[i][j]);
          o_rot = o_rot | fet_pkg::sat_hit(rs[i][j]);
          o_dir = o_dir | fet_pkg::sat_hit(ds[i][j]) | fet_pkg::sat_hit(cs[i][j]);
        end
        coef.trn[i] <= fet_pkg::sat_word(ts[i]);
        coef.pln[i] <= fet_pkg::sat_word(ps[i]);
        o_trn = o_trn | fet_pkg::sat_hit(ts[i]);
        o_pln = o_pln | fet_pkg::sat_hit(ps[i]);
      end
      coef.ovf_rot <= o_rot;
      coef.ovf_dir <= o_dir;
      coef.ovf_trn <= o_trn;
      coef.ovf_pln <= o_pln;
    end
  end

endmodule

// ===== rtl/flector_element_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flector_element_transform
// Applies a configured flector to a stream of geometric elements in Q format.
// ----------------------------------------------------------------------------
// Channel   Role    Handshake            Payload
// elem      in      valid/ready          action, in_a .. in_f
// result    out     valid/ready          out_a .. out_f, overflow
// apb       config  psel/penable/pready  paddr, pwdata, prdata
//
// Four register stages: register products, coefficient sums, coefficient
// times input products, result sums into the output register. An item is
// accepted every cycle unless all stages are full and the result side is
// stalled. Reset clears the configuration registers and all stage valid
// bits. Each stage holds while the one after it is full and stalled, so a
// bubble is filled while the output waits.
// ----------------------------------------------------------------------------
module flector_element_transform #(
  parameter int FRAC_BITS = fet_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  fet_elem_if.sink                 elem,
  fet_result_if.source             result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [fet_pkg::AW-1:0]   paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = fet_pkg::SUM_W;

  logic [fet_pkg::NREG-1:0][fet_pkg::DW-1:0] cfg;
  logic [fet_pkg::RIDX_W-1:0] ridx;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  fet_pkg::coef_ctl_t ctl;
  fet_pkg::coef_t coef;

  logic [2:0]      act1, act2, act3, act4;
  fet_pkg::word_t  x1 [6];
  fet_pkg::word_t  x2 [6];
  fet_pkg::word_t  x3 [6];
  fet_pkg::word_t  trn3 [3];
  logic            ovf3;

  logic signed [PW-1:0] mp [3][3];
  logic signed [PW-1:0] mr [3][3];
  logic signed [PW-1:0] mc [3][3];
  logic signed [PW-1:0] pp [3];

  logic signed [SW-1:0] acc [6];
  fet_pkg::word_t       res_next [6];
  logic                 ovf_next;

  function automatic logic signed [PW-1:0] qm(input fet_pkg::word_t a,
                                              input fet_pkg::word_t b);
    return PW'(fet_pkg::qmul(a, b, FRAC_BITS));
  endfunction

  function automatic logic signed [SW-1:0] ex(input logic signed [PW-1:0] v);
    return SW'(v);
  endfunction

  // Configuration registers.
  assign ridx   = paddr[fet_pkg::AW-1:2];
  assign pready = 1'b1;
  assign prdata = cfg[ridx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      cfg[ridx] <= pwdata;
    end
  end

  // Stage enables.
  assign en4 = !v4 || result.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign elem.ready = en1;
  assign ctl.en1 = en1;
  assign ctl.en2 = en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= elem.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  fet_coef #(
    .FRAC_BITS (FRAC_BITS)
  ) u_coef (
    .clk  (clk),
    .cfg  (cfg),
    .ctl  (ctl),
    .coef (coef)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      act1  <= elem.action;
      x1[0] <= elem.in_a;
      x1[1] <= elem.in_b;
      x1[2] <= elem.in_c;
      x1[3] <= elem.in_d;
      x1[4] <= elem.in_e;
      x1[5] <= elem.in_f;
    end
    if (en2) begin
      act2 <= act1;
      x2   <= x1;
    end
  end

  // Coefficient times input products.
  always_ff @(posedge clk) begin
    logic is_line;
    if (en3) begin
      is_line = (act2 == fet_pkg::ACT_LINE);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp[i][j] <= qm(is_line ? coef.dirm[i][j] : coef.rot[i][j], x2[j]);
          mr[i][j] <= qm(coef.rot[i][j], x2[j+3]);
          mc[i][j] <= qm(coef.cpl[i][j], x2[j]);
        end
        pp[i]   <= qm(coef.pln[i], x2[i]);
        trn3[i] <= coef.trn[i];
      end
      act3 <= act2;
      x3   <= x2;
      ovf3 <= coef.ovf_rot
           || (act2 == fet_pkg::ACT_POINT && coef.ovf_trn)
           || (is_line && coef.ovf_dir)
           || (act2 == fet_pkg::ACT_PLANE && coef.ovf_pln);
    end
  end

  // Result sums and saturation.
  always_comb begin
    logic signed [SW-1:0] s;
    logic valid_act;
    valid_act = (act3 == fet_pkg::ACT_VECTOR) || (act3 == fet_pkg::ACT_BIVECTOR)
             || (act3 == fet_pkg::ACT_POINT) || (act3 == fet_pkg::ACT_LINE)
             || (act3 == fet_pkg::ACT_PLANE);
    for (int i = 0; i < 3; i++) begin
      s = ex(mp[i][0]) + ex(mp[i][1]) + ex(mp[i][2]);
      if (act3 == fet_pkg::ACT_POINT) begin
        s = s + SW'(trn3[i]);
      end
      acc[i] = SW'(x3[i]) + (s <<< 1);
      s = ex(mr[i][0]) + ex(mr[i][1]) + ex(mr[i][2])
        + ex(mc[i][0]) + ex(mc[i][1]) + ex(mc[i][2]);
      acc[i+3] = SW'(x3[i+3]) + (s <<< 1);
    end
    if (act3 == fet_pkg::ACT_PLANE) begin
      s = ex(pp[0]) + ex(pp[1]) + ex(pp[2]);
      acc[3] = SW'(x3[3]) + (s <<< 1);
    end
    ovf_next = ovf3;
    for (int i = 0; i < 6; i++) begin
      res_next[i] = fet_pkg::sat_word(acc[i]);
    end
    for (int i = 0; i < 3; i++) begin
      ovf_next = ovf_next | fet_pkg::sat_hit(acc[i]);
    end
    case (act3)
      fet_pkg::ACT_LINE: begin
        for (int i = 3; i < 6; i++) begin
          ovf_next = ovf_next | fet_pkg::sat_hit(acc[i]);
        end
      end
      fet_pkg::ACT_PLANE: begin
        ovf_next = ovf_next | fet_pkg::sat_hit(acc[3]);
        res_next[4] = '0;
        res_next[5] = '0;
      end
      default: begin
        for (int i = 3; i < 6; i++) begin
          res_next[i] = '0;
        end
      end
    endcase
    if (!valid_act) begin
      for (int i = 0; i < 6; i++) begin
        res_next[i] = '0;
      end
      ovf_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      act4            <= act3;
      result.out_a    <= res_next[0];
      result.out_b    <= res_next[1];
      result.out_c    <= res_next[2];
      result.out_d    <= res_next[3];
      result.out_e    <= res_next[4];
      result.out_f    <= res_next[5];
      result.overflow <= ovf_next;
    end
  end

  assign result.valid = v4;

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && v4 && !result.ready |-> !elem.ready)
    else $error("pipeline full and stalled but still ready");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    en4 && v3 |=> v4)
    else $error("item lost between last stages");

  a_moment_zero: assert property (@(posedge clk) disable iff (rst)
    v4 && act4 != fet_pkg::ACT_LINE |-> result.out_e == '0 && result.out_f == '0)
    else $error("moment fields set for a kind without them");

  a_bad_action: assert property (@(posedge clk) disable iff (rst)
    v4 && act4 != fet_pkg::ACT_VECTOR && act4 != fet_pkg::ACT_BIVECTOR
      && act4 != fet_pkg::ACT_POINT && act4 != fet_pkg::ACT_LINE
      && act4 != fet_pkg::ACT_PLANE |-> !result.overflow && result.out_a == '0)
    else $error("undefined action gave a nonzero result");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flector element transform.
// A table of directed elements is run first, then fixed and random flectors
// with elements of every kind, with random gaps on both channels. Each result
// is compared with the table or a fixed-point model of the sandwich formulas.
// ----------------------------------------------------------------------------
module tb;

  localparam int AW = fet_pkg::AW;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] v [6];
  } elem_t;

  typedef struct {
    logic [31:0] o [6];
    logic        ovf;
  } res_t;

  typedef struct {
    elem_t e;
    logic  known;
    res_t  r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fet_elem_if elem_ch ();
  fet_result_if res_ch ();

  flector_element_transform dut (
    .clk(clk), .rst(rst), .elem(elem_ch.sink), .result(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  longint flector [8];
  res_t   pending [$];
  int     errors = 0;
  int     cycles = 0;
  logic   sat_seen;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint rmul(longint a, longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic longint clamp(longint x);
    if (x > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic void mat_apply(longint k [3][3], longint x [3], longint add [3],
                                    output longint y [3]);
    longint s;
    for (int i = 0; i < 3; i++) begin
      s = add[i];
      for (int j = 0; j < 3; j++) s += rmul(k[i][j], x[j]);
      y[i] = clamp(x[i] + 2 * s);
    end
  endfunction

  function automatic res_t transform_element(elem_t e);
    res_t r;
    longint sx, sy, sz, sw, hx, hy, hz, hw;
    longint sw2, hx2, hy2, hz2, hyhz, hzhx, hxhy, hxsw, hysw, hzsw;
    longint rot [3][3];
    longint dm [3][3];
    longint cp [3][3];
    longint a [6];
    longint x [3];
    longint m [3];
    longint z [3];
    longint t [3];
    longint y [3];
    longint y2 [3];
    longint c0, c1, c2;
    sx = flector[fet_pkg::REG_SX]; sy = flector[fet_pkg::REG_SY];
    sz = flector[fet_pkg::REG_SZ]; sw = flector[fet_pkg::REG_SW];
    hx = flector[fet_pkg::REG_HX]; hy = flector[fet_pkg::REG_HY];
    hz = flector[fet_pkg::REG_HZ]; hw = flector[fet_pkg::REG_HW];
    sat_seen = 1'b0;
    for (int i = 0; i < 6; i++) begin
      a[i] = longint'($signed(e.v[i]));
      r.o[i] = '0;
    end
    r.ovf = 1'b0;
    if (e.act > fet_pkg::ACT_PLANE) return r;
    for (int i = 0; i < 3; i++) begin
      x[i] = a[i]; m[i] = a[i+3]; z[i] = 0;
    end
    sw2 = rmul(sw, sw); hx2 = rmul(hx, hx); hy2 = rmul(hy, hy); hz2 = rmul(hz, hz);
    hyhz = rmul(hy, hz); hzhx = rmul(hz, hx); hxhy = rmul(hx, hy);
    hxsw = rmul(hx, sw); hysw = rmul(hy, sw); hzsw = rmul(hz, sw);
    rot[0][0] = clamp(-(hx2 + sw2)); rot[0][1] = clamp(hzsw - hxhy);
    rot[0][2] = clamp(-(hzhx + hysw)); rot[1][0] = clamp(-(hxhy + hzsw));
    rot[1][1] = clamp(-(hy2 + sw2)); rot[1][2] = clamp(hxsw - hyhz);
    rot[2][0] = clamp(hysw - hzhx); rot[2][1] = clamp(-(hyhz + hxsw));
    rot[2][2] = clamp(-(hz2 + sw2));
    case (e.act)
      fet_pkg::ACT_VECTOR, fet_pkg::ACT_BIVECTOR: begin
        mat_apply(rot, x, z, y);
      end
      fet_pkg::ACT_POINT: begin
        t[0] = clamp(rmul(sx, sw) - rmul(hx, hw) + rmul(hy, sz) - rmul(hz, sy));
        t[1] = clamp(rmul(sy, sw) - rmul(hy, hw) + rmul(hz, sx) - rmul(hx, sz));
        t[2] = clamp(rmul(sz, sw) - rmul(hz, hw) + rmul(hx, sy) - rmul(hy, sx));
        mat_apply(rot, x, t, y);
      end
      fet_pkg::ACT_LINE: begin
        dm[0][0] = clamp(-(hy2 + hz2)); dm[0][1] = clamp(hxhy - hzsw);
        dm[0][2] = clamp(hzhx + hysw); dm[1][0] = clamp(hxhy + hzsw);
        dm[1][1] = clamp(-(hz2 + hx2)); dm[1][2] = clamp(hyhz - hxsw);
        dm[2][0] = clamp(hzhx - hysw); dm[2][1] = clamp(hyhz + hxsw);
        dm[2][2] = clamp(-(hx2 + hy2));
        cp[0][0] = clamp(-2 * (rmul(hy, sy) + rmul(hz, sz)));
        cp[0][1] = clamp(rmul(hx, sy) + rmul(hy, sx) - rmul(sz, sw) - rmul(hz, hw));
        cp[0][2] = clamp(rmul(hx, sz) + rmul(hz, sx) + rmul(sy, sw) + rmul(hy, hw));
        cp[1][0] = clamp(rmul(hy, sx) + rmul(hx, sy) + rmul(sz, sw) + rmul(hz, hw));
        cp[1][1] = clamp(-2 * (rmul(hz, sz) + rmul(hx, sx)));
        cp[1][2] = clamp(rmul(hy, sz) + rmul(hz, sy) - rmul(sx, sw) - rmul(hx, hw));
        cp[2][0] = clamp(rmul(hz, sx) + rmul(hx, sz) - rmul(sy, sw) - rmul(hy, hw));
        cp[2][1] = clamp(rmul(hz, sy) + rmul(hy, sz) + rmul(sx, sw) + rmul(hx, hw));
        cp[2][2] = clamp(-2 * (rmul(hx, sx) + rmul(hy, sy)));
        mat_apply(dm, x, z, y);
        for (int i = 0; i < 3; i++) begin
          t[i] = 0;
          for (int j = 0; j < 3; j++) t[i] += rmul(cp[i][j], x[j]);
        end
        mat_apply(rot, m, t, y2);
        for (int i = 0; i < 3; i++) r.o[i+3] = y2[i][31:0];
      end
      default: begin
        mat_apply(rot, x, z, y);
        c0 = clamp(rmul(sx, sw) - rmul(hx, hw) - rmul(hy, sz) + rmul(hz, sy));
        c1 = clamp(rmul(sy, sw) - rmul(hy, hw) - rmul(hz, sx) + rmul(hx, sz));
        c2 = clamp(rmul(sz, sw) - rmul(hz, hw) - rmul(hx, sy) + rmul(hy, sx));
        r.o[3] = 32'(clamp(a[3] + 2 * (rmul(c0, a[0]) + rmul(c1, a[1])
                                       + rmul(c2, a[2]))));
      end
    endcase
    for (int i = 0; i < 3; i++) r.o[i] = y[i][31:0];
    r.ovf = sat_seen;
    return r;
  endfunction

  task automatic write_reg(fet_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AW'(4 * int'(idx)); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    flector[idx] = longint'($signed(val));
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic load_flector(logic [31:0] f [8]);
    for (int i = 0; i < 8; i++) write_reg(fet_pkg::reg_idx_t'(i), f[i]);
  endtask

  task automatic drain();
    @(negedge clk);
    elem_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send(elem_t e, logic known, res_t r);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      @(negedge clk);
      elem_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    elem_ch.valid <= 1'b1;
    elem_ch.action <= e.act;
    elem_ch.in_a <= e.v[0]; elem_ch.in_b <= e.v[1]; elem_ch.in_c <= e.v[2];
    elem_ch.in_d <= e.v[3]; elem_ch.in_e <= e.v[4]; elem_ch.in_f <= e.v[5];
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    pending.push_back(known ? r : transform_element(e));
  endtask

  task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s[%0d]: got %h expected %h", what, idx, got, want);
  endtask

  // Result side: random stall before each item, checked at the rising edge.
  initial begin
    int stall;
    res_t want;
    logic [31:0] got [6];
    res_ch.ready = 1'b0;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      got = '{res_ch.out_a, res_ch.out_b, res_ch.out_c,
              res_ch.out_d, res_ch.out_e, res_ch.out_f};
      if (pending.size() == 0) begin
        report("unexpected", 0, got[0], 32'h0);
      end else begin
        want = pending.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[i] !== want.o[i]) report("out", i, got[i], want.o[i]);
        if (res_ch.overflow !== want.ovf)
          report("overflow", 0, {31'b0, res_ch.overflow}, {31'b0, want.ovf});
      end
    end
  end

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
    endcase
  endfunction

  initial begin
    row_t rows [$];
    row_t row;
    elem_t e;
    res_t zero_res;
    logic [31:0] f [8];
    res_t dummy;
    elem_ch.valid = 1'b0;
    elem_ch.action = '0;
    elem_ch.in_a = '0; elem_ch.in_b = '0; elem_ch.in_c = '0;
    elem_ch.in_d = '0; elem_ch.in_e = '0; elem_ch.in_f = '0;
    foreach (flector[i]) flector[i] = 0;
    for (int i = 0; i < 6; i++) zero_res.o[i] = '0;
    zero_res.ovf = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset the flector is zero: valid kinds pass through, others give zero.
    for (int k = 0; k < 8; k++) begin
      row.e.act = 3'(k);
      row.e.v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                  32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321};
      row.known = 1'b1;
      row.r = zero_res;
      if (k <= 4) for (int i = 0; i < 3; i++) row.r.o[i] = row.e.v[i];
      if (k == fet_pkg::ACT_LINE) for (int i = 3; i < 6; i++) row.r.o[i] = row.e.v[i];
      if (k == fet_pkg::ACT_PLANE) row.r.o[3] = row.e.v[3];
      rows.push_back(row);
    end
    foreach (rows[i]) send(rows[i].e, rows[i].known, rows[i].r);
    drain();

    // A unit reflection, then extreme registers that saturate the coefficients.
    f = '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0};
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) f = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      if (phase == 2) f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      load_flector(f);
      for (int k = 0; k < 5; k++) begin
        e.act = 3'(k);
        e.v = '{32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0001_8000, 32'hFFFF_FFFF, 32'h0000_0001};
        send(e, 1'b0, dummy);
      end
      drain();
    end

    for (int phase = 0; phase < 12; phase++) begin
      for (int i = 0; i < 8; i++)
        f[i] = (phase % 3 == 0) ? rnd_word()
             : 32'($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
      load_flector(f);
      for (int n = 0; n < 150; n++) begin
        e.act = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
        for (int i = 0; i < 6; i++) e.v[i] = rnd_word();
        send(e, 1'b0, dummy);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
